### src/bso_pkg.sv
// shared codes and types for the box and sphere overlap test
`default_nettype none

package bso_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BOX    = 2'd1;
    localparam logic [1:0] KIND_SPHERE = 2'd2;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_BOX_BOX = 3'd1,
        MODE_BOX_SPH = 3'd2,
        MODE_SPH_BOX = 3'd3,
        MODE_SPH_SPH = 3'd4
    } mode_t;

endpackage

`default_nettype wire

### src/bso_axis.sv
// per-axis distance, box overlap and box-to-sphere gap
`default_nettype none

module bso_axis #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic signed [COORD_WIDTH-1:0] c_s,
    input  wire logic        [COORD_WIDTH-2:0] e_s,
    input  wire logic signed [COORD_WIDTH-1:0] c_t,
    input  wire logic        [COORD_WIDTH-2:0] e_t,
    input  wire logic                          box_stored,
    output logic                               box_ok,
    output logic             [COORD_WIDTH-1:0] gap,
    output logic             [COORD_WIDTH-1:0] cdist
);

    localparam int CW = COORD_WIDTH;
    localparam int W  = CW + 2;

    logic signed [W-1:0] cs_x, ct_x, es_x, et_x;
    logic signed [W-1:0] bc, be, sc, lo, hi, lo_gap, hi_gap, diff, diff_abs;
    logic        [CW-1:0] esum;

    assign cs_x = {{2{c_s[CW-1]}}, c_s};
    assign ct_x = {{2{c_t[CW-1]}}, c_t};
    assign es_x = {3'b000, e_s};
    assign et_x = {3'b000, e_t};

    // center distance, used by box-box and sphere-sphere
    assign diff     = cs_x - ct_x;
    assign diff_abs = (diff < 0) ? -diff : diff;
    assign cdist    = diff_abs[CW-1:0];
    assign esum     = {1'b0, e_s} + {1'b0, e_t};
    assign box_ok   = (cdist <= esum);

    // gap from sphere center to box faces
    assign bc     = box_stored ? cs_x : ct_x;
    assign be     = box_stored ? es_x : et_x;
    assign sc     = box_stored ? ct_x : cs_x;
    assign lo     = bc - be;
    assign hi     = bc + be;
    assign lo_gap = lo - sc;
    assign hi_gap = sc - hi;

    always_comb begin
        if (lo > sc) begin
            gap = lo_gap[CW-1:0];
        end else if (hi < sc) begin
            gap = hi_gap[CW-1:0];
        end else begin
            gap = '0;
        end
    end

endmodule

`default_nettype wire

### src/bso_hit.sv
// squarers, sum and final hit decision
`default_nettype none

module bso_hit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire bso_pkg::mode_t                  mode,
    input  wire logic                            box_ok [3],
    input  wire logic        [COORD_WIDTH-1:0]   gap    [3],
    input  wire logic        [COORD_WIDTH-1:0]   cdist  [3],
    input  wire logic        [COORD_WIDTH-2:0]   e_s0,
    input  wire logic        [COORD_WIDTH-2:0]   e_t0,
    output logic                                 hit
);

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0]   op  [3];
    logic [2*CW-1:0] sq  [3];
    logic [CW-1:0]   rad;
    logic [2*CW-1:0] rsq;
    logic [2*CW+1:0] sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            op[i] = (mode == bso_pkg::MODE_SPH_SPH) ? cdist[i] : gap[i];
            sq[i] = op[i] * op[i];
        end
    end

    always_comb begin
        unique case (mode)
            bso_pkg::MODE_SPH_SPH: rad = {1'b0, e_s0} + {1'b0, e_t0};
            bso_pkg::MODE_BOX_SPH: rad = {1'b0, e_t0};
            default:               rad = {1'b0, e_s0};
        endcase
    end

    assign rsq = rad * rad;
    assign sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

    always_comb begin
        unique case (mode)
            bso_pkg::MODE_BOX_BOX: hit = box_ok[0] & box_ok[1] & box_ok[2];
            bso_pkg::MODE_BOX_SPH,
            bso_pkg::MODE_SPH_BOX,
            bso_pkg::MODE_SPH_SPH: hit = (sum <= {2'b00, rsq});
            default:               hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### src/box_sphere_overlap_test.sv
// top level of the box and sphere overlap test
//
// channel  dir  tdata                                     tuser
// s_       in   center x,y,z then extent x,y,z            req_type, shape_kind
// m_       out  collides                                  -
//
// one request per cycle while the result is not stalled; the single evaluation
// stage (three axis squarers plus the radius squarer) sits between the input and
// result registers; load requests update the stored object and give no result
// reset clears the stored kind to none and empties both registers
// a stalled result holds; a test request waits in the input register
`default_nettype none

module box_sphere_overlap_test #(
    parameter  int COORD_WIDTH = 16,
    localparam int S_TDATA_W   = ((6 * COORD_WIDTH - 3 + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cx, cy, cz, ex, ey, ez from bit 0 up, zero padded
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type, shape_kind from bit 0 up
    input  wire logic [2:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // collides at bit 0, zero padded
    output logic [7:0]                m_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = COORD_WIDTH - 1;

    logic                 in_valid_reg;
    logic                 in_req_reg;
    logic [1:0]           in_kind_reg;
    logic signed [CW-1:0] in_c_reg [3];
    logic [EW-1:0]        in_e_reg [3];

    logic [1:0]           st_kind_reg;
    logic signed [CW-1:0] st_c_reg [3];
    logic [EW-1:0]        st_e_reg [3];

    logic                 m_valid_reg;
    logic                 m_collides_reg;

    logic                 out_free;
    logic                 proceed;
    logic                 is_load;
    bso_pkg::mode_t       mode;
    logic                 box_stored;
    logic                 box_ok [3];
    logic [CW-1:0]        gap    [3];
    logic [CW-1:0]        cdist  [3];
    logic                 hit;

    assign is_load  = (in_req_reg == bso_pkg::REQ_LOAD);
    assign out_free = !m_valid_reg || m_tready;
    assign proceed  = in_valid_reg && (is_load || out_free);
    assign s_tready = !in_valid_reg || proceed;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_collides_reg};

    always_comb begin
        unique case ({st_kind_reg, in_kind_reg})
            {bso_pkg::KIND_BOX,    bso_pkg::KIND_BOX}:    mode = bso_pkg::MODE_BOX_BOX;
            {bso_pkg::KIND_BOX,    bso_pkg::KIND_SPHERE}: mode = bso_pkg::MODE_BOX_SPH;
            {bso_pkg::KIND_SPHERE, bso_pkg::KIND_BOX}:    mode = bso_pkg::MODE_SPH_BOX;
            {bso_pkg::KIND_SPHERE, bso_pkg::KIND_SPHERE}: mode = bso_pkg::MODE_SPH_SPH;
            default:                                      mode = bso_pkg::MODE_NONE;
        endcase
    end

    assign box_stored = (st_kind_reg == bso_pkg::KIND_BOX);

    for (genvar i = 0; i < 3; i++) begin : g_axis
        bso_axis #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_axis (
            .c_s       (st_c_reg[i]),
            .e_s       (st_e_reg[i]),
            .c_t       (in_c_reg[i]),
            .e_t       (in_e_reg[i]),
            .box_stored(box_stored),
            .box_ok    (box_ok[i]),
            .gap       (gap[i]),
            .cdist     (cdist[i])
        );
    end

    bso_hit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_hit (
        .mode  (mode),
        .box_ok(box_ok),
        .gap   (gap),
        .cdist (cdist),
        .e_s0  (st_e_reg[0]),
        .e_t0  (in_e_reg[0]),
        .hit   (hit)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_kind_reg  <= bso_pkg::KIND_NONE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proceed && is_load) begin
                st_kind_reg <= in_kind_reg;
            end
            if (out_free) begin
                m_valid_reg <= proceed && !is_load;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser[0];
            in_kind_reg <= s_tuser[2:1];
            in_c_reg[0] <= s_tdata[CW-1:0];
            in_c_reg[1] <= s_tdata[2*CW-1:CW];
            in_c_reg[2] <= s_tdata[3*CW-1:2*CW];
            in_e_reg[0] <= s_tdata[3*CW+EW-1:3*CW];
            in_e_reg[1] <= s_tdata[3*CW+2*EW-1:3*CW+EW];
            in_e_reg[2] <= s_tdata[3*CW+3*EW-1:3*CW+2*EW];
        end
        if (proceed && is_load) begin
            for (int i = 0; i < 3; i++) begin
                st_c_reg[i] <= in_c_reg[i];
                st_e_reg[i] <= in_e_reg[i];
            end
        end
        if (proceed && !is_load) begin
            m_collides_reg <= hit;
        end
    end

    a_test_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !is_load && out_free) |=> m_valid_reg)
        else $error("test request did not produce a result");

    a_load_stores_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && is_load) |=> (st_kind_reg == $past(in_kind_reg)))
        else $error("load request did not update stored kind");

    a_none_never_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !is_load && out_free &&
         (st_kind_reg == bso_pkg::KIND_NONE || in_kind_reg == bso_pkg::KIND_NONE))
        |=> !m_collides_reg)
        else $error("hit reported with a none object");

endmodule

`default_nettype wire
